// ===== rtl/per_source_ip_traffic_counter_defines.svh =====
// Assertion macros for the traffic counter RTL, used by psitc_ctrl.
`ifndef PER_SOURCE_IP_TRAFFIC_COUNTER_DEFINES_SVH
`define PER_SOURCE_IP_TRAFFIC_COUNTER_DEFINES_SVH
`ifndef ASSERT_OFF
`define PSITC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PSITC_ASSERT_RST(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PSITC_ASSERT(lbl, clk, rst, prop, msg)
`define PSITC_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/psitc_pkg.sv =====
// Types and constants shared by the traffic counter modules.
package psitc_pkg;
   localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_TCP     = 8'd6;
   localparam logic [7:0]  PROTO_UDP     = 8'd17;
   localparam logic [15:0] MIN_CAPTURE   = 16'd34;

   typedef struct packed {
      logic [15:0] captured_len;
      logic [15:0] ether_type;
      logic [31:0] src_ip;
      logic [7:0]  ip_protocol;
      logic [15:0] ip_total_len;
   } req_type;

   typedef struct packed {
      logic        counted;
      logic        new_entry;
      logic [63:0] tcp_byte_sum;
      logic [63:0] tcp_pkt_count;
      logic [63:0] udp_byte_sum;
      logic [63:0] udp_pkt_count;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic hash;
      logic read;
      logic look;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
   } sts_type;
endpackage

// ===== rtl/psitc_ctrl.sv =====
// Sequencing state machine for the traffic counter.
`include "per_source_ip_traffic_counter_defines.svh"
module psitc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  psitc_pkg::sts_type sts,
   output psitc_pkg::cmd_type cmd
);
   import psitc_pkg::*;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_HASH  = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_LOOK  = 3'd4;
   localparam logic [2:0] ST_ADD   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            cmd.hash = 1'b1;
            state_in = ST_READ;
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_LOOK;
         end
         ST_LOOK: begin
            cmd.look = 1'b1;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `PSITC_ASSERT(a_accept_starts, clock, reset, (req_valid && !req_stall) |=> (state_ff == ST_HASH), "accepted beat did not start hashing")
   `PSITC_ASSERT(a_commit_free, clock, reset, cmd.commit |-> out_free, "result written over an untaken beat")
   `PSITC_ASSERT(a_one_cmd, clock, reset, $onehot0(cmd), "more than one command at once")
   `PSITC_ASSERT_RST(a_reset_clears, clock, reset |=> (state_ff == ST_CLEAR && !rsp_valid_ff), "reset did not start the clearing pass")
endmodule

// ===== rtl/psitc_dp.sv =====
// Datapath: set hash, table memory, lookup, counter update and result register.
module psitc_dp #(
   parameter int TABLE_ENTRIES = 1024,
   parameter int NUM_WAYS      = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  psitc_pkg::req_type req_data,
   input  psitc_pkg::cmd_type cmd,
   output psitc_pkg::sts_type sts,
   output psitc_pkg::rsp_type rsp_data
);
   import psitc_pkg::*;

   localparam int SET_COUNT = (TABLE_ENTRIES / NUM_WAYS) > 0 ? (TABLE_ENTRIES / NUM_WAYS) : 1;
   localparam int SET_W     = SET_COUNT > 1 ? $clog2(SET_COUNT) : 1;
   localparam int WAY_W     = NUM_WAYS > 1 ? $clog2(NUM_WAYS) : 1;
   localparam logic [32:0] RECIP   = 33'((64'd1 << 32) / SET_COUNT);
   localparam logic [31:0] SET_CNT = 32'(SET_COUNT);

   typedef struct packed {
      logic             valid;
      logic [31:0]      addr;
      logic [WAY_W-1:0] rank;
      logic [63:0]      tcp_byte_sum;
      logic [63:0]      tcp_pkt_count;
      logic [63:0]      udp_byte_sum;
      logic [63:0]      udp_pkt_count;
   } way_type;

   way_type [NUM_WAYS-1:0] mem [SET_COUNT];

   req_type                item_ff;
   logic                   counted_ff;
   logic [31:0]            quot_ff;
   logic [SET_W-1:0]       set_ff, clear_idx_ff;
   way_type [NUM_WAYS-1:0] row_ff, clear_row, new_row;
   logic [WAY_W-1:0]       way_ff, way_in;
   logic                   hit_ff, hit_in;
   rsp_type                rsp_ff, rsp_in;
   logic [31:0]            fold, rem, rem_adj;
   logic [64:0]            prod;
   logic [63:0]            prod2;
   way_type                base, upd;

   assign fold  = item_ff.src_ip ^ {16'd0, item_ff.src_ip[31:16]};
   assign prod  = 65'(fold) * 65'(RECIP);
   assign prod2 = 64'(quot_ff) * 64'(SET_CNT);
   assign rem   = fold - prod2[31:0];
   assign rem_adj = (rem >= SET_CNT) ? rem - SET_CNT : rem;
   assign sts.clear_last = (clear_idx_ff == SET_W'(SET_COUNT - 1));
   assign rsp_data = rsp_ff;

   always_comb begin
      for (int w = 0; w < NUM_WAYS; w++) begin
         clear_row[w]      = '0;
         clear_row[w].rank = WAY_W'(w);
      end
   end

   // hit has priority; otherwise take the least recently used way
   always_comb begin
      hit_in = 1'b0;
      way_in = '0;
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         if (row_ff[w].rank == WAY_W'(NUM_WAYS - 1) && !hit_in) way_in = WAY_W'(w);
      end
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         if (row_ff[w].valid && row_ff[w].addr == item_ff.src_ip) begin
            hit_in = 1'b1;
            way_in = WAY_W'(w);
         end
      end
   end

   always_comb begin
      base = row_ff[way_ff];
      if (!hit_ff) begin
         base.tcp_byte_sum  = '0;
         base.tcp_pkt_count = '0;
         base.udp_byte_sum  = '0;
         base.udp_pkt_count = '0;
      end
      upd       = base;
      upd.valid = 1'b1;
      upd.addr  = item_ff.src_ip;
      upd.rank  = '0;
      if (item_ff.ip_protocol == PROTO_TCP) begin
         upd.tcp_pkt_count = base.tcp_pkt_count + 64'd1;
         upd.tcp_byte_sum  = base.tcp_byte_sum + 64'(item_ff.ip_total_len);
      end else begin
         upd.udp_pkt_count = base.udp_pkt_count + 64'd1;
         upd.udp_byte_sum  = base.udp_byte_sum + 64'(item_ff.ip_total_len);
      end
      new_row = row_ff;
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (row_ff[w].rank < base.rank) new_row[w].rank = row_ff[w].rank + 1'b1;
      end
      new_row[way_ff] = upd;
   end

   always_comb begin
      rsp_in = '0;
      if (counted_ff) begin
         rsp_in.counted       = 1'b1;
         rsp_in.new_entry     = !hit_ff;
         rsp_in.tcp_byte_sum  = upd.tcp_byte_sum;
         rsp_in.tcp_pkt_count = upd.tcp_pkt_count;
         rsp_in.udp_byte_sum  = upd.udp_byte_sum;
         rsp_in.udp_pkt_count = upd.udp_pkt_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) clear_idx_ff <= '0;
      else if (cmd.clear) clear_idx_ff <= clear_idx_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) mem[clear_idx_ff] <= clear_row;
      else if (cmd.commit && counted_ff) mem[set_ff] <= new_row;
      if (cmd.read) row_ff <= mem[rem_adj[SET_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff    <= req_data;
         counted_ff <= (req_data.captured_len >= MIN_CAPTURE) &&
                       (req_data.ether_type == ETH_TYPE_IPV4) &&
                       (req_data.src_ip != 32'd0) &&
                       (req_data.ip_protocol == PROTO_TCP ||
                        req_data.ip_protocol == PROTO_UDP);
      end
      if (cmd.hash) quot_ff <= prod[63:32];
      if (cmd.read) set_ff <= rem_adj[SET_W-1:0];
      if (cmd.look) begin
         hit_ff <= hit_in;
         way_ff <= way_in;
      end
      if (cmd.commit) rsp_ff <= rsp_in;
   end
endmodule

// ===== rtl/per_source_ip_traffic_counter.sv =====
// Top level of the per-source IPv4 traffic counter.
//
// Counts TCP and UDP packets and bytes per IPv4 source address in a
// set-associative table of TABLE_ENTRIES slots, NUM_WAYS ways per set, with
// true LRU replacement inside each set. The set is the XOR fold of the
// address (upper half into lower half) modulo the set count. A packet counts
// only with captured length of at least 34, ethertype IPv4, a nonzero source
// and protocol TCP or UDP; every request beat gets one response beat, and an
// uncounted packet returns zeros. Each beat is one table row read-modify-write
// through a single memory: accept, hash (reciprocal multiply), row read, way
// match, counter add and write-back. After reset the block walks every set of
// the table to clear valid bits and recency, holding req_stall high. A finished
// response sits in an output register, so the next request is taken while it
// waits.
module per_source_ip_traffic_counter #(
   parameter int TABLE_ENTRIES = 1024,
   parameter int NUM_WAYS      = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  psitc_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output psitc_pkg::rsp_type rsp_data
);
   import psitc_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequence each beat through the table
   psitc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // hold the table and compute the counters
   psitc_dp #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .NUM_WAYS      (NUM_WAYS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );
endmodule

// ===== bench/per_source_ip_traffic_counter_test.sv =====
// Testbench for the per-source IPv4 traffic counter: random and directed headers, LRU table check.
module per_source_ip_traffic_counter_test;
   timeunit 1ns;
   timeprecision 1ps;
   import psitc_pkg::*;

   localparam int TABLE_ENTRIES = 1024;
   localparam int NUM_WAYS      = 4;
   localparam int SET_COUNT     = (TABLE_ENTRIES / NUM_WAYS) > 0 ? TABLE_ENTRIES / NUM_WAYS : 1;
   localparam int SLOT_COUNT    = SET_COUNT * NUM_WAYS;
   localparam int RANDOM_BEATS  = 500;
   // Covers the clearing walk after reset plus long stalls.
   localparam int IDLE_LIMIT    = 20000;

   // Scoreboard: mirrors the flow table and queues the counter values each header should return.
   class flow_table_scoreboard;
      logic [31:0] slot_addr[SLOT_COUNT];
      bit          slot_used[SLOT_COUNT];
      logic [63:0] tcp_b[SLOT_COUNT], tcp_p[SLOT_COUNT], udp_b[SLOT_COUNT], udp_p[SLOT_COUNT];
      int          rank[SLOT_COUNT];
      rsp_type     pending_counts[$];
      int          errors;

      function new();
         errors = 0;
         for (int s = 0; s < SLOT_COUNT; s++) begin
            slot_used[s] = 0;
            rank[s] = s % NUM_WAYS;
         end
      endfunction

      function void note_header(req_type h);
         rsp_type r;
         int base, way, slot, oldr, best;
         bit hit;
         r = '0;
         hit = 0;
         way = 0;
         if (h.captured_len >= MIN_CAPTURE && h.ether_type == ETH_TYPE_IPV4 && h.src_ip != 0 &&
             (h.ip_protocol == PROTO_TCP || h.ip_protocol == PROTO_UDP)) begin
            base = int'((h.src_ip ^ (h.src_ip >> 16)) % SET_COUNT) * NUM_WAYS;
            for (int w = NUM_WAYS - 1; w >= 0; w--)
               if (slot_used[base + w] && slot_addr[base + w] == h.src_ip) begin
                  way = w;
                  hit = 1;
               end
            if (!hit) begin
               // take the least recently used way; ties go to the highest index
               best = 0;
               for (int w = 0; w < NUM_WAYS; w++)
                  if (rank[base + w] >= best) begin
                     best = rank[base + w];
                     way = w;
                  end
               slot = base + way;
               slot_used[slot] = 1;
               slot_addr[slot] = h.src_ip;
               tcp_b[slot] = 0; tcp_p[slot] = 0; udp_b[slot] = 0; udp_p[slot] = 0;
            end
            slot = base + way;
            if (h.ip_protocol == PROTO_TCP) begin
               tcp_p[slot] += 64'd1;
               tcp_b[slot] += {48'd0, h.ip_total_len};
            end else begin
               udp_p[slot] += 64'd1;
               udp_b[slot] += {48'd0, h.ip_total_len};
            end
            oldr = rank[slot];
            for (int w = 0; w < NUM_WAYS; w++)
               if (rank[base + w] < oldr) rank[base + w]++;
            rank[slot] = 0;
            r.counted = 1;
            r.new_entry = !hit;
            r.tcp_byte_sum = tcp_b[slot];
            r.tcp_pkt_count = tcp_p[slot];
            r.udp_byte_sum = udp_b[slot];
            r.udp_pkt_count = udp_p[slot];
         end
         pending_counts.push_back(r);
      endfunction

      function void check_counts(rsp_type got);
         rsp_type want;
         if (pending_counts.size() == 0) begin
            $display("%0t: unexpected response beat %h", $realtime, got);
            errors++;
            return;
         end
         want = pending_counts.pop_front();
         if (got.counted !== want.counted)
            $display("%0t: counted expected %0d actual %0d", $realtime, want.counted, got.counted);
         if (got.new_entry !== want.new_entry)
            $display("%0t: new_entry expected %0d actual %0d", $realtime, want.new_entry,
                     got.new_entry);
         if (got.tcp_byte_sum !== want.tcp_byte_sum)
            $display("%0t: tcp_byte_sum expected %h actual %h", $realtime, want.tcp_byte_sum,
                     got.tcp_byte_sum);
         if (got.tcp_pkt_count !== want.tcp_pkt_count)
            $display("%0t: tcp_pkt_count expected %h actual %h", $realtime, want.tcp_pkt_count,
                     got.tcp_pkt_count);
         if (got.udp_byte_sum !== want.udp_byte_sum)
            $display("%0t: udp_byte_sum expected %h actual %h", $realtime, want.udp_byte_sum,
                     got.udp_byte_sum);
         if (got.udp_pkt_count !== want.udp_pkt_count)
            $display("%0t: udp_pkt_count expected %h actual %h", $realtime, want.udp_pkt_count,
                     got.udp_pkt_count);
         if (got !== want) errors++;
      endfunction
   endclass

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   rsp_type rsp_data;

   flow_table_scoreboard flows = new();
   int  idle_cycles = 0;
   bit  sending_done = 0;
   // Small address pool so hits, evictions and set conflicts happen often.
   logic [31:0] addr_pool[16];

   per_source_ip_traffic_counter #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .NUM_WAYS     (NUM_WAYS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always #6 clock = ~clock;

   // Sample both channels at the rising edge; a beat moves when valid is high and stall low.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) flows.note_header(req_data);
         if (rsp_valid && !rsp_stall) flows.check_counts(rsp_data);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // Receiver stall pattern: quiet stretches, then bursts of random back-pressure.
   always @(negedge clock) begin
      int phase;
      phase = int'(($time / 12) % 400);
      if (phase < 80) rsp_stall <= 0;
      else if (phase < 200) rsp_stall <= ($urandom_range(0, 3) == 0);
      else rsp_stall <= ($urandom_range(0, 1) == 0);
   end

   // Present one header and hold it until the block takes it.
   task automatic send_header(req_type h);
      req_valid <= 1;
      req_data  <= h;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic send_gap();
      req_valid <= 0;
      req_data  <= req_type'(88'({$urandom, $urandom, $urandom}));
      repeat ($urandom_range(1, 6)) @(negedge clock);
   endtask

   function automatic req_type good_header(logic [31:0] ip, logic [7:0] proto, logic [15:0] len);
      req_type h;
      h.captured_len = 16'($urandom_range(MIN_CAPTURE, 16'hFFFF));
      h.ether_type   = ETH_TYPE_IPV4;
      h.src_ip       = ip;
      h.ip_protocol  = proto;
      h.ip_total_len = len;
      return h;
   endfunction

   function automatic req_type random_header();
      req_type h;
      int pick;
      pick = $urandom_range(0, 9);
      h = good_header(addr_pool[$urandom_range(0, 15)],
                      $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP, 16'($urandom));
      if (pick == 7) h.src_ip = $urandom;
      // drop one qualifying condition at a time, with random content
      if (pick == 8) begin
         case ($urandom_range(0, 3))
            0: h.captured_len = 16'($urandom_range(0, MIN_CAPTURE - 1));
            1: h.ether_type = 16'($urandom);
            2: h.src_ip = 0;
            default: h.ip_protocol = 8'($urandom);
         endcase
      end
      if (pick == 9) h = req_type'(88'({$urandom, $urandom, $urandom}));
      return h;
   endfunction

   initial begin
      req_type h;
      int burst;
      for (int i = 0; i < 16; i++)
         addr_pool[i] = (i < 8) ? $urandom : {16'h5A5A, 16'h5A5A ^ 16'(i)} ;
      // the upper eight fold into the same set, forcing LRU eviction
      for (int i = 8; i < 16; i++) addr_pool[i] = {16'(i * 16'h1111), 16'(i * 16'h1111) ^ 16'h0007};
      repeat (8) @(negedge clock);
      reset <= 0;

      // Directed: rejection cases and field extremes.
      send_header(good_header(32'hFFFF_FFFF, PROTO_TCP, 16'hFFFF));
      send_header(good_header(32'hFFFF_FFFF, PROTO_UDP, 16'h0000));
      send_header(good_header(32'h0000_0001, PROTO_UDP, 16'hFFFF));
      h = good_header(32'h0A00_0001, PROTO_TCP, 16'd60); h.captured_len = 16'd33;
      send_header(h);
      h.captured_len = 16'd34; send_header(h);
      h.captured_len = 16'd14; send_header(h);
      h.captured_len = 16'd0;  send_header(h);
      h = good_header(32'h0A00_0001, PROTO_TCP, 16'd60); h.ether_type = 16'h86DD;
      send_header(h);
      h.ether_type = 16'hFFFF; send_header(h);
      h = good_header(32'h0, PROTO_UDP, 16'd60); send_header(h);
      h = good_header(32'h0A00_0001, 8'd1, 16'd60); send_header(h);
      h = good_header(32'h0A00_0001, 8'hFF, 16'd60); send_header(h);
      h = good_header(32'h0A00_0001, 8'd0, 16'd60); send_header(h);
      // five addresses into one set: fill the ways, then evict the oldest
      for (int i = 8; i < 13; i++) send_header(good_header(addr_pool[i], PROTO_UDP, 16'(i)));
      send_header(good_header(addr_pool[8], PROTO_TCP, 16'd1));
      send_header(good_header(addr_pool[12], PROTO_TCP, 16'd2));
      send_gap();

      // Random part: bursts of headers, gaps between them.
      for (int n = 0; n < RANDOM_BEATS; ) begin
         burst = $urandom_range(1, 20);
         for (int b = 0; b < burst; b++, n++) send_header(random_header());
         if ($urandom_range(0, 2) != 0) send_gap();
      end
      req_valid <= 0;
      sending_done = 1;
   end

   initial begin
      wait (sending_done);
      while (flows.pending_counts.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (flows.errors == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/psitc_pkg.sv
rtl/psitc_ctrl.sv
rtl/psitc_dp.sv
rtl/per_source_ip_traffic_counter.sv
bench/per_source_ip_traffic_counter_test.sv
